// ===== hdl/satc_pkg.sv =====
package satc_pkg;

   // table size and derived widths
   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int CMD_W       = 3;
   localparam int SLOT_W      = 4;
   localparam int HOUR_W      = 5;
   localparam int MINUTE_W    = 6;
   localparam int TIME_W      = HOUR_W + MINUTE_W;
   localparam int COUNT_OUT_W = 5;
   localparam int STATUS_W    = 2;
   localparam int CMP_W       = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // minute-of-day arithmetic
   localparam int MIN_W        = 11;
   localparam int DAY_W        = MIN_W + 1;
   localparam int HOUR_MAX     = 23;
   localparam int MINUTE_MAX   = 59;
   localparam int MIN_PER_DAY  = 1440;
   // divide by 60 as multiply by 2185 and shift right by 17 (exact below 1440)
   localparam int RECIP_60     = 2185;
   localparam int RECIP_W      = 12;
   localparam int RECIP_SHIFT  = 17;
   localparam int PROD_W       = MIN_W + RECIP_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_EDIT   = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_READ   = 3'd4,
      CMD_QUERY  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      PTR_HOLD    = 3'd0,
      PTR_SLOT    = 3'd1,
      PTR_COUNT   = 3'd2,
      PTR_ZERO    = 3'd3,
      PTR_INC     = 3'd4,
      PTR_DEC     = 3'd5,
      PTR_CNT_DEC = 3'd6
   } ptr_op_type;

   typedef enum logic [1:0] {
      ADDR_AT   = 2'd0,
      ADDR_UP   = 2'd1,
      ADDR_DOWN = 2'd2
   } addr_op_type;

   typedef enum logic [1:0] {
      WR_NONE  = 2'd0,
      WR_NEW   = 2'd1,
      WR_SHIFT = 2'd2
   } wr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD  = 2'd0,
      CNT_INC   = 2'd1,
      CNT_DEC   = 2'd2,
      CNT_CLEAR = 2'd3
   } cnt_op_type;

   // controller to datapath
   typedef struct packed {
      logic        capture;
      ptr_op_type  ptr_op;
      addr_op_type addr_op;
      wr_op_type   wr_op;
      cnt_op_type  cnt_op;
      logic        res_clear;
      logic        status_load;
      status_type  status;
      logic        entry_load;
      logic        first_load;
      logic        hit_load;
      logic        hit_wrap;
      logic        diff_load;
      logic        quot_load;
      logic        rem_load;
      logic        out_load;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    empty;
      logic    full;
      logic    slot_oob;
      logic    ptr_zero;
      logic    next_ok;
      logic    ge_new;
   } dp_stat_type;

endpackage

// ===== hdl/satc_channels.sv =====
interface satc_req_if import satc_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SLOT_W-1:0]   slot;
   logic [HOUR_W-1:0]   hour;
   logic [MINUTE_W-1:0] minute;

   modport source (output valid, output cmd, output slot, output hour, output minute,
                   input ready);
   modport sink (input valid, input cmd, input slot, input hour, input minute,
                 output ready);
endinterface

interface satc_rsp_if import satc_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [HOUR_W-1:0]      entry_hour;
   logic [MINUTE_W-1:0]    entry_minute;
   logic [HOUR_W-1:0]      wait_hours;
   logic [MINUTE_W-1:0]    wait_minutes;
   logic [COUNT_OUT_W-1:0] entry_count;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, output entry_hour, output entry_minute,
                   output wait_hours, output wait_minutes, output entry_count,
                   output status, input ready);
   modport sink (input valid, input entry_hour, input entry_minute,
                 input wait_hours, input wait_minutes, input entry_count,
                 input status, output ready);
endinterface

// ===== hdl/satc_ram.sv =====
module satc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/satc_dpath.sv =====
module satc_dpath import satc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request payload
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [SLOT_W-1:0]      req_slot,
   input  logic [HOUR_W-1:0]      req_hour,
   input  logic [MINUTE_W-1:0]    req_minute,
   // controller link
   input  dp_cmd_type             ctl,
   output dp_stat_type            stat,
   // table memory
   output logic                   ram_we,
   output logic [IDX_W-1:0]       ram_waddr,
   output logic [TIME_W-1:0]      ram_wdata,
   output logic [IDX_W-1:0]       ram_raddr,
   input  logic [TIME_W-1:0]      ram_rdata,
   // response payload
   output logic [HOUR_W-1:0]      rsp_entry_hour,
   output logic [MINUTE_W-1:0]    rsp_entry_minute,
   output logic [HOUR_W-1:0]      rsp_wait_hours,
   output logic [MINUTE_W-1:0]    rsp_wait_minutes,
   output logic [COUNT_OUT_W-1:0] rsp_entry_count,
   output logic [STATUS_W-1:0]    rsp_status
);

   // h * 60 + m by shifts
   function automatic logic [MIN_W-1:0] day_minutes(input logic [TIME_W-1:0] t);
      logic [MIN_W-1:0] h;
      logic [MIN_W-1:0] m;
      h = MIN_W'(t[TIME_W-1:MINUTE_W]);
      m = MIN_W'(t[MINUTE_W-1:0]);
      return (h << 6) - (h << 2) + m;
   endfunction

   cmd_type             cmd_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [TIME_W-1:0]   new_ff;
   logic [MIN_W-1:0]    now_min_ff;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    ptr_plus;
   logic [CNT_W-1:0]    raddr_full;
   logic [TIME_W-1:0]   first_ff;
   logic [TIME_W-1:0]   hit_ff;
   logic                wrap_ff;
   logic [MIN_W-1:0]    diff_ff;
   logic [HOUR_W-1:0]   quot_ff;
   logic [HOUR_W-1:0]   eh_ff;
   logic [MINUTE_W-1:0] em_ff;
   logic [HOUR_W-1:0]   wh_ff;
   logic [MINUTE_W-1:0] wm_ff;
   status_type          status_ff;

   logic [HOUR_W-1:0]   hour_sat;
   logic [MINUTE_W-1:0] minute_sat;
   logic [TIME_W-1:0]   new_time;
   logic [DAY_W-1:0]    diff_sum;
   logic [PROD_W-1:0]   prod;
   logic [MIN_W-1:0]    quot_x60;

   // clamp the incoming time
   assign hour_sat   = (req_hour > HOUR_W'(HOUR_MAX)) ? HOUR_W'(HOUR_MAX) : req_hour;
   assign minute_sat = (req_minute > MINUTE_W'(MINUTE_MAX)) ?
                       MINUTE_W'(MINUTE_MAX) : req_minute;
   assign new_time   = {hour_sat, minute_sat};

   // captured request
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff     <= cmd_type'(req_cmd);
         slot_ff    <= req_slot;
         new_ff     <= new_time;
         now_min_ff <= day_minutes(new_time);
      end
   end

   // entry count
   always_comb begin
      unique case (ctl.cnt_op)
         CNT_HOLD:  count_in = count_ff;
         CNT_INC:   count_in = count_ff + CNT_W'(1);
         CNT_DEC:   count_in = count_ff - CNT_W'(1);
         CNT_CLEAR: count_in = '0;
         default:   count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // walk pointer
   assign ptr_plus = ptr_ff + CNT_W'(1);

   always_comb begin
      unique case (ctl.ptr_op)
         PTR_HOLD:    ptr_in = ptr_ff;
         PTR_SLOT:    ptr_in = CNT_W'(slot_ff);
         PTR_COUNT:   ptr_in = count_ff;
         PTR_ZERO:    ptr_in = '0;
         PTR_INC:     ptr_in = ptr_plus;
         PTR_DEC:     ptr_in = ptr_ff - CNT_W'(1);
         PTR_CNT_DEC: ptr_in = count_ff - CNT_W'(1);
         default:     ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
   end

   // read at, one above or one below the next pointer
   always_comb begin
      unique case (ctl.addr_op)
         ADDR_AT:   raddr_full = ptr_in;
         ADDR_UP:   raddr_full = ptr_in + CNT_W'(1);
         ADDR_DOWN: raddr_full = ptr_in - CNT_W'(1);
         default:   raddr_full = ptr_in;
      endcase
   end

   assign ram_raddr = raddr_full[IDX_W-1:0];
   assign ram_we    = (ctl.wr_op != WR_NONE);
   assign ram_waddr = ptr_ff[IDX_W-1:0];
   assign ram_wdata = (ctl.wr_op == WR_NEW) ? new_ff : ram_rdata;

   // status to controller
   assign stat.cmd      = cmd_ff;
   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff >= CNT_W'(CAPACITY));
   assign stat.slot_oob = (CMP_W'(slot_ff) >= CMP_W'(count_ff));
   assign stat.ptr_zero = (ptr_ff == '0);
   assign stat.next_ok  = (ptr_plus < count_ff);
   assign stat.ge_new   = (ram_rdata >= new_ff);

   // next-time search and countdown arithmetic
   assign diff_sum = DAY_W'(day_minutes(hit_ff))
                   + (wrap_ff ? DAY_W'(MIN_PER_DAY) : DAY_W'(0))
                   - DAY_W'(now_min_ff);
   assign prod     = PROD_W'(diff_ff) * PROD_W'(RECIP_60);
   assign quot_x60 = (MIN_W'(quot_ff) << 6) - (MIN_W'(quot_ff) << 2);

   always_ff @(posedge clock) begin
      if (ctl.first_load) begin
         first_ff <= ram_rdata;
      end
      if (ctl.hit_load) begin
         hit_ff  <= (ctl.hit_wrap && !stat.ptr_zero) ? first_ff : ram_rdata;
         wrap_ff <= ctl.hit_wrap;
      end
      if (ctl.diff_load) begin
         diff_ff <= diff_sum[MIN_W-1:0];
      end
      if (ctl.quot_load) begin
         quot_ff <= prod[RECIP_SHIFT +: HOUR_W];
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (ctl.res_clear) begin
         eh_ff <= '0;
         em_ff <= '0;
         wh_ff <= '0;
         wm_ff <= '0;
      end else begin
         if (ctl.entry_load) begin
            eh_ff <= ram_rdata[TIME_W-1:MINUTE_W];
            em_ff <= ram_rdata[MINUTE_W-1:0];
         end
         if (ctl.diff_load) begin
            eh_ff <= hit_ff[TIME_W-1:MINUTE_W];
            em_ff <= hit_ff[MINUTE_W-1:0];
         end
         if (ctl.rem_load) begin
            wh_ff <= quot_ff;
            wm_ff <= MINUTE_W'(diff_ff - quot_x60);
         end
      end
      if (ctl.status_load) begin
         status_ff <= ctl.status;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_entry_hour   <= eh_ff;
         rsp_entry_minute <= em_ff;
         rsp_wait_hours   <= wh_ff;
         rsp_wait_minutes <= wm_ff;
         rsp_entry_count  <= COUNT_OUT_W'(count_ff);
         rsp_status       <= status_ff;
      end
   end

endmodule

// ===== hdl/satc_ctrl.sv =====
module satc_ctrl import satc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  ctl
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b00_0000_0001,
      S_DECODE = 10'b00_0000_0010,
      S_INSERT = 10'b00_0000_0100,
      S_DELETE = 10'b00_0000_1000,
      S_READ   = 10'b00_0001_0000,
      S_SCAN   = 10'b00_0010_0000,
      S_DIFF   = 10'b00_0100_0000,
      S_DIV    = 10'b00_1000_0000,
      S_REM    = 10'b01_0000_0000,
      S_FINISH = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      ctl          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end

         S_DECODE: begin
            ctl.res_clear   = 1'b1;
            ctl.status_load = 1'b1;
            ctl.status      = ST_OK;
            state_in        = S_FINISH;
            unique case (stat.cmd)
               CMD_ADD: begin
                  if (stat.full) begin
                     ctl.status = ST_FULL;
                  end else begin
                     ctl.ptr_op  = PTR_COUNT;
                     ctl.addr_op = ADDR_DOWN;
                     state_in    = S_INSERT;
                  end
               end
               CMD_REMOVE, CMD_EDIT: begin
                  if (stat.empty) begin
                     ctl.status = ST_EMPTY;
                  end else if (stat.slot_oob) begin
                     ctl.status = ST_RANGE;
                  end else begin
                     ctl.ptr_op  = PTR_SLOT;
                     ctl.addr_op = ADDR_UP;
                     state_in    = S_DELETE;
                  end
               end
               CMD_CLEAR: begin
                  ctl.cnt_op = CNT_CLEAR;
               end
               CMD_READ: begin
                  if (stat.empty) begin
                     ctl.status = ST_EMPTY;
                  end else if (stat.slot_oob) begin
                     ctl.status = ST_RANGE;
                  end else begin
                     ctl.ptr_op  = PTR_SLOT;
                     ctl.addr_op = ADDR_AT;
                     state_in    = S_READ;
                  end
               end
               CMD_QUERY: begin
                  if (stat.empty) begin
                     ctl.status = ST_EMPTY;
                  end else begin
                     ctl.ptr_op  = PTR_ZERO;
                     ctl.addr_op = ADDR_AT;
                     state_in    = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end

         // move entries at or above the new time up until the new time fits
         S_INSERT: begin
            if (stat.ptr_zero || !stat.ge_new) begin
               ctl.wr_op  = WR_NEW;
               ctl.cnt_op = CNT_INC;
               state_in   = S_FINISH;
            end else begin
               ctl.wr_op   = WR_SHIFT;
               ctl.ptr_op  = PTR_DEC;
               ctl.addr_op = ADDR_DOWN;
            end
         end

         // close the gap left by the removed slot
         S_DELETE: begin
            if (stat.next_ok) begin
               ctl.wr_op   = WR_SHIFT;
               ctl.ptr_op  = PTR_INC;
               ctl.addr_op = ADDR_UP;
            end else begin
               ctl.cnt_op = CNT_DEC;
               if (stat.cmd == CMD_EDIT) begin
                  ctl.ptr_op  = PTR_CNT_DEC;
                  ctl.addr_op = ADDR_DOWN;
                  state_in    = S_INSERT;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_READ: begin
            ctl.entry_load = 1'b1;
            state_in       = S_FINISH;
         end

         // first entry at or after now, else wrap to the first entry
         S_SCAN: begin
            ctl.first_load = stat.ptr_zero;
            if (stat.ge_new) begin
               ctl.hit_load = 1'b1;
               state_in     = S_DIFF;
            end else if (stat.next_ok) begin
               ctl.ptr_op  = PTR_INC;
               ctl.addr_op = ADDR_AT;
            end else begin
               ctl.hit_load = 1'b1;
               ctl.hit_wrap = 1'b1;
               state_in     = S_DIFF;
            end
         end

         S_DIFF: begin
            ctl.diff_load = 1'b1;
            state_in      = S_DIV;
         end

         S_DIV: begin
            ctl.quot_load = 1'b1;
            state_in      = S_REM;
         end

         S_REM: begin
            ctl.rem_load = 1'b1;
            state_in     = S_FINISH;
         end

         // hand the result over once the output register is free
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/sorted_alarm_table_countdown_unit.sv =====
// Sorted daily alarm table. Holds up to CAPACITY HH:MM times in ascending order in a
// single-port-write, registered-read RAM and answers one request at a time with exactly
// one response: add, remove by slot, edit (remove then add), clear, read a slot, or
// query the wait from a given time to the next stored time (wrapping to the first entry
// of the next day). Hours above 23 and minutes above 59 are clamped. The table is walked
// one entry per cycle through the RAM port: an add moves up the entries at or above the
// new time, a remove shifts down the entries above its slot, an edit does both and a
// query scans from the first entry. A new request is taken while the previous response
// still waits in the output register.
module sorted_alarm_table_countdown_unit import satc_pkg::*; (
   input logic         clock,
   input logic         reset,
   satc_req_if.sink    req_if,
   satc_rsp_if.source  rsp_if
);

   dp_cmd_type         ctl;
   dp_stat_type        stat;
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [TIME_W-1:0]  ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [TIME_W-1:0]  ram_rdata;

   satc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   satc_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_cmd          (req_if.cmd),
      .req_slot         (req_if.slot),
      .req_hour         (req_if.hour),
      .req_minute       (req_if.minute),
      .ctl              (ctl),
      .stat             (stat),
      .ram_we           (ram_we),
      .ram_waddr        (ram_waddr),
      .ram_wdata        (ram_wdata),
      .ram_raddr        (ram_raddr),
      .ram_rdata        (ram_rdata),
      .rsp_entry_hour   (rsp_if.entry_hour),
      .rsp_entry_minute (rsp_if.entry_minute),
      .rsp_wait_hours   (rsp_if.wait_hours),
      .rsp_wait_minutes (rsp_if.wait_minutes),
      .rsp_entry_count  (rsp_if.entry_count),
      .rsp_status       (rsp_if.status)
   );

   satc_ram #(
      .WIDTH (TIME_W),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule

// ===== bench/sorted_alarm_table_countdown_unit_tb.sv =====
`timescale 1ns / 1ps

import satc_pkg::*;

// one response of the alarm table, field for field
typedef struct packed {
   logic [HOUR_W-1:0]      entry_hour;
   logic [MINUTE_W-1:0]    entry_minute;
   logic [HOUR_W-1:0]      wait_hours;
   logic [MINUTE_W-1:0]    wait_minutes;
   logic [COUNT_OUT_W-1:0] entry_count;
   status_type             status;
} alarm_answer_type;

// Shadow copy of the sorted table: applies each accepted request and keeps the answers
// the block owes, oldest first.
class alarm_table_shadow;
   localparam int MIN_PER_HOUR = 60;

   logic [TIME_W-1:0] times [CAPACITY];
   int unsigned       stored = 0;
   alarm_answer_type  answers_due [$];
   int unsigned       errors = 0;
   int unsigned       matched = 0;
   int unsigned       full_hits = 0;
   int unsigned       range_hits = 0;
   int unsigned       empty_hits = 0;
   int unsigned       wraps = 0;
   int unsigned       zero_waits = 0;

   function int unsigned day_minute(logic [TIME_W-1:0] t);
      return t[TIME_W-1:MINUTE_W] * MIN_PER_HOUR + t[MINUTE_W-1:0];
   endfunction

   // new time goes ahead of any equal entry
   function void place_time(logic [TIME_W-1:0] t);
      int unsigned pos;
      pos = 0;
      while (pos < stored && times[pos] < t)
         pos++;
      for (int unsigned i = stored; i > pos; i--)
         times[i] = times[i-1];
      times[pos] = t;
      stored++;
   endfunction

   function void apply_request(logic [CMD_W-1:0] cmd, logic [SLOT_W-1:0] slot,
                               logic [HOUR_W-1:0] hour, logic [MINUTE_W-1:0] minute);
      alarm_answer_type    ans;
      logic [HOUR_W-1:0]   hh;
      logic [MINUTE_W-1:0] mm;
      logic [TIME_W-1:0]   t;
      logic [TIME_W-1:0]   hit;
      int unsigned         now_min;
      int unsigned         i;
      int unsigned         gap;
      ans = '0;
      // clamp out-of-range clock values
      hh = (hour > HOUR_MAX) ? HOUR_W'(HOUR_MAX) : hour;
      mm = (minute > MINUTE_MAX) ? MINUTE_W'(MINUTE_MAX) : minute;
      t = {hh, mm};
      case (cmd)
         CMD_ADD: begin
            if (stored >= CAPACITY)
               ans.status = ST_FULL;
            else
               place_time(t);
         end
         CMD_REMOVE, CMD_EDIT: begin
            if (stored == 0)
               ans.status = ST_EMPTY;
            else if (slot >= stored)
               ans.status = ST_RANGE;
            else begin
               for (i = slot; i + 1 < stored; i++)
                  times[i] = times[i+1];
               stored--;
               if (cmd == CMD_EDIT)
                  place_time(t);
            end
         end
         CMD_CLEAR: begin
            stored = 0;
         end
         CMD_READ: begin
            if (stored == 0)
               ans.status = ST_EMPTY;
            else if (slot >= stored)
               ans.status = ST_RANGE;
            else begin
               ans.entry_hour   = times[slot][TIME_W-1:MINUTE_W];
               ans.entry_minute = times[slot][MINUTE_W-1:0];
            end
         end
         CMD_QUERY: begin
            if (stored == 0)
               ans.status = ST_EMPTY;
            else begin
               // first entry at or after now, else first entry tomorrow
               now_min = day_minute(t);
               i = 0;
               while (i < stored && day_minute(times[i]) < now_min)
                  i++;
               if (i < stored) begin
                  hit = times[i];
                  gap = day_minute(hit) - now_min;
               end else begin
                  hit = times[0];
                  gap = day_minute(hit) + MIN_PER_DAY - now_min;
                  wraps++;
               end
               if (gap == 0)
                  zero_waits++;
               ans.entry_hour   = hit[TIME_W-1:MINUTE_W];
               ans.entry_minute = hit[MINUTE_W-1:0];
               ans.wait_hours   = HOUR_W'(gap / MIN_PER_HOUR);
               ans.wait_minutes = MINUTE_W'(gap % MIN_PER_HOUR);
            end
         end
         default: ;
      endcase
      case (ans.status)
         ST_FULL:  full_hits++;
         ST_RANGE: range_hits++;
         ST_EMPTY: empty_hits++;
         default: ;
      endcase
      ans.entry_count = COUNT_OUT_W'(stored);
      answers_due.push_back(ans);
   endfunction

   function bit field_differs(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got)
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      return want !== got;
   endfunction

   function void check_answer(alarm_answer_type got);
      alarm_answer_type want;
      bit               bad;
      if (answers_due.size() == 0) begin
         errors++;
         $display("%0t: response with no request outstanding, got %h", $time, got);
         return;
      end
      want = answers_due.pop_front();
      bad = 0;
      bad |= field_differs("entry_hour", want.entry_hour, got.entry_hour);
      bad |= field_differs("entry_minute", want.entry_minute, got.entry_minute);
      bad |= field_differs("wait_hours", want.wait_hours, got.wait_hours);
      bad |= field_differs("wait_minutes", want.wait_minutes, got.wait_minutes);
      bad |= field_differs("entry_count", want.entry_count, got.entry_count);
      bad |= field_differs("status", want.status, got.status);
      if (bad)
         errors++;
      else
         matched++;
   endfunction
endclass

module sorted_alarm_table_countdown_unit_tb;

   localparam int CLK_PERIOD      = 10;
   localparam int TOTAL_REQUESTS  = 1900;
   localparam int MIXED_PER_ROUND = 120;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 2 * CAPACITY + 12;
   localparam int IDLE_PERCENT    = 13;
   localparam logic [CMD_W-1:0] CMD_NOP_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_NOP_7 = 3'd7;

   logic clock;
   logic reset;

   satc_req_if req_if ();
   satc_rsp_if rsp_if ();

   alarm_table_shadow shadow = new();

   bit          quiet = 1'b0;
   bit          hold_off_due = 1'b0;
   int unsigned sent = 0;
   int unsigned hold_offs_done = 0;

   sorted_alarm_table_countdown_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #6000000;
      $display("Timeout at %0t with %0d answers outstanding", $time,
               shadow.answers_due.size());
      $display("*** FAILED ***");
      $finish;
   end

   // offer one request and hold it until the block takes it
   task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot,
                               input logic [HOUR_W-1:0] hour,
                               input logic [MINUTE_W-1:0] minute);
      req_if.valid  <= 1'b1;
      req_if.cmd    <= cmd;
      req_if.slot   <= slot;
      req_if.hour   <= hour;
      req_if.minute <= minute;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      shadow.apply_request(cmd, slot, hour, minute);
      if (cmd < CMD_NOP_6)
         sent++;
      // random gap before the next request
      if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // sender stops until every outstanding answer is back
   task automatic wait_for_answers();
      if (shadow.answers_due.size() != 0) begin
         req_if.valid <= 1'b0;
         while (shadow.answers_due.size() != 0)
            @(posedge clock);
      end
   endtask

   // time for add, edit or query: often a stored time, sometimes clamped or extreme
   task automatic pick_time(output logic [HOUR_W-1:0] hour,
                            output logic [MINUTE_W-1:0] minute);
      int unsigned       r;
      logic [TIME_W-1:0] t;
      r = $urandom_range(99);
      if (r < 10) begin
         hour   = HOUR_W'($urandom_range(31));
         minute = MINUTE_W'($urandom_range(63));
      end else if (r < 35 && shadow.stored > 0) begin
         t = shadow.times[$urandom_range(shadow.stored - 1)];
         hour   = t[TIME_W-1:MINUTE_W];
         minute = t[MINUTE_W-1:0];
      end else if (r < 45) begin
         hour   = $urandom_range(1) ? HOUR_W'(HOUR_MAX) : '0;
         minute = $urandom_range(1) ? MINUTE_W'(MINUTE_MAX) : '0;
      end else begin
         hour   = HOUR_W'($urandom_range(HOUR_MAX));
         minute = MINUTE_W'($urandom_range(MINUTE_MAX));
      end
   endtask

   // response side: check each accepted response, then pick next ready
   initial begin
      alarm_answer_type got;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            got.entry_hour   = rsp_if.entry_hour;
            got.entry_minute = rsp_if.entry_minute;
            got.wait_hours   = rsp_if.wait_hours;
            got.wait_minutes = rsp_if.wait_minutes;
            got.entry_count  = rsp_if.entry_count;
            got.status       = status_type'(rsp_if.status);
            shadow.check_answer(got);
         end
         if (hold_off_due) begin
            // long back-pressure so the block fills and stalls its input
            rsp_if.ready <= 1'b0;
            for (int c = 0; c < HOLD_OFF_CYCLES; c++)
               @(posedge clock);
            hold_off_due = 1'b0;
            hold_offs_done++;
         end else begin
            rsp_if.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // stimulus
   initial begin
      logic [CMD_W-1:0]    cmd;
      logic [SLOT_W-1:0]   slot;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      int unsigned         r;
      bit                  filling;

      reset         <= 1'b1;
      req_if.valid  <= 1'b0;
      req_if.cmd    <= CMD_ADD;
      req_if.slot   <= '0;
      req_if.hour   <= '0;
      req_if.minute <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table
      send_request(CMD_QUERY, 4'd0, 5'd0, 6'd0);
      send_request(CMD_REMOVE, 4'd0, 5'd0, 6'd0);
      send_request(CMD_EDIT, 4'd0, 5'd1, 6'd1);
      send_request(CMD_READ, 4'd0, 5'd0, 6'd0);
      // extremes, clamped values and an equal time
      send_request(CMD_ADD, 4'd0, 5'd23, 6'd59);
      send_request(CMD_ADD, 4'd15, 5'd0, 6'd0);
      send_request(CMD_ADD, 4'd0, 5'd31, 6'd63);
      send_request(CMD_ADD, 4'd0, 5'd12, 6'd30);
      // reads in and out of range
      send_request(CMD_READ, 4'd0, 5'd0, 6'd0);
      send_request(CMD_READ, 4'd3, 5'd0, 6'd0);
      send_request(CMD_READ, 4'd4, 5'd0, 6'd0);
      send_request(CMD_READ, 4'd15, 5'd31, 6'd63);
      // queries: exact hit, ordinary, clamped now
      send_request(CMD_QUERY, 4'd0, 5'd12, 6'd30);
      send_request(CMD_QUERY, 4'd0, 5'd12, 6'd31);
      send_request(CMD_QUERY, 4'd0, 5'd30, 6'd62);
      // removal and edit
      send_request(CMD_REMOVE, 4'd15, 5'd0, 6'd0);
      send_request(CMD_REMOVE, 4'd3, 5'd0, 6'd0);
      send_request(CMD_EDIT, 4'd0, 5'd23, 6'd58);
      send_request(CMD_REMOVE, 4'd2, 5'd0, 6'd0);
      // past the last entry: wraps to next day
      send_request(CMD_QUERY, 4'd0, 5'd23, 6'd59);
      send_request(CMD_NOP_6, 4'd0, 5'd0, 6'd0);
      send_request(CMD_NOP_7, 4'd15, 5'd31, 6'd63);
      send_request(CMD_CLEAR, 4'd0, 5'd0, 6'd0);
      send_request(CMD_QUERY, 4'd0, 5'd5, 6'd5);
      // longest wait: one minute past the only entry
      send_request(CMD_ADD, 4'd0, 5'd0, 6'd0);
      send_request(CMD_QUERY, 4'd0, 5'd0, 6'd1);
      wait_for_answers();

      // random rounds
      for (int round = 0; sent < TOTAL_REQUESTS; round++) begin
         quiet = (round == 3);
         if (round == 5)
            hold_off_due = 1'b1;
         filling = (round % 2 == 0);

         // fill burst: clear, fill past capacity, then query
         if (round % 3 == 0) begin
            send_request(CMD_CLEAR, SLOT_W'($urandom_range(15)), '0, '0);
            for (int k = 0; k <= CAPACITY; k++) begin
               pick_time(hour, minute);
               send_request(CMD_ADD, SLOT_W'($urandom_range(15)), hour, minute);
            end
            for (int k = 0; k < 4; k++) begin
               pick_time(hour, minute);
               send_request(CMD_QUERY, SLOT_W'($urandom_range(15)), hour, minute);
            end
         end

         // mixed traffic, biased toward growing or shrinking the table
         for (int k = 0; k < MIXED_PER_ROUND; k++) begin
            r = $urandom_range(99);
            if (r < (filling ? 40 : 20))
               cmd = CMD_ADD;
            else if (r < (filling ? 48 : 45))
               cmd = CMD_REMOVE;
            else if (r < (filling ? 60 : 58))
               cmd = CMD_EDIT;
            else if (r < 71)
               cmd = CMD_READ;
            else if (r < 95)
               cmd = CMD_QUERY;
            else if (r < 97)
               cmd = CMD_CLEAR;
            else
               cmd = $urandom_range(1) ? CMD_NOP_6 : CMD_NOP_7;
            if (shadow.stored > 0 && $urandom_range(99) < 80)
               slot = SLOT_W'($urandom_range(shadow.stored - 1));
            else
               slot = SLOT_W'($urandom_range(15));
            pick_time(hour, minute);
            send_request(cmd, slot, hour, minute);
         end

         if (round % 2 == 1)
            wait_for_answers();
      end

      // drain and let any stray response show up
      wait_for_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests, %0d answers matched: %0d full-table adds, %0d bad slots,",
               sent, shadow.matched, shadow.full_hits, shadow.range_hits);
      $display("%0d empty-table requests, %0d wrapped queries, %0d zero waits, %0d long stalls.",
               shadow.empty_hits, shadow.wraps, shadow.zero_waits, hold_offs_done);
      if (shadow.errors == 0 && shadow.answers_due.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/satc_pkg.sv
hdl/satc_channels.sv
hdl/satc_ram.sv
hdl/satc_dpath.sv
hdl/satc_ctrl.sv
hdl/sorted_alarm_table_countdown_unit.sv
bench/sorted_alarm_table_countdown_unit_tb.sv
